[hdl/gil_pkg.sv]
// -----------------------------------------------------------------------------
// gil_pkg
// Shared types and constants for the glyph index lookup block.
// -----------------------------------------------------------------------------
package gil_pkg;

   localparam int CODE_W     = 21;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int GLYPH_W    = 12;
   localparam int DIRECT_W   = 7;
   localparam int DIRECT_SIZE = 128;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic REG_FB_ENABLE = 1'b0;
   localparam logic REG_FB_CODE   = 1'b1;

   localparam logic             FB_ENABLE_RESET = 1'b1;
   localparam logic [DIRECT_W-1:0] FB_CODE_RESET = 7'd42;

   typedef struct packed {
      logic                enable;
      logic [DIRECT_W-1:0] code;
   } cfg_type;

   typedef struct packed {
      logic                used_fallback;
      logic [GLYPH_W-1:0]  glyph_index;
      logic [STATUS_W-1:0] status;
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_DIRECT,
      ST_FALLBACK,
      ST_DONE
   } state_type;

endpackage

[hdl/glyph_index_lookup.sv]
// -----------------------------------------------------------------------------
// glyph_index_lookup
// Maps a character code to a glyph slot through a direct map for low codes
// and a binary search over a sorted code table for the rest.
// -----------------------------------------------------------------------------
// One word at a time is processed: a clear, append or lookup must finish
// before the next word is accepted. A lookup of a code below 128 uses the
// direct map. A lookup of a higher code reads the code table once per cycle
// through its single read port, about log2(N)+1 reads for N loaded entries
// (13 for 4096). A missed lookup may be retried with the fallback code,
// read from the direct map. The result sits in an output register, so the
// next word is taken while the previous result still waits on rsp_tready.
// -----------------------------------------------------------------------------
module glyph_index_lookup
   import gil_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // code[20:0], zero pad
   input  logic [1:0]            req_tuser,   // kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // glyph_index[11:0], zero pad
   output logic [2:0]            rsp_tuser,   // status[1:0], used_fallback[2]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   res_type eng_res;
   logic    eng_valid;
   logic    eng_take;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff, rsp_res_in;

   gil_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gil_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_code  (req_tdata[CODE_W-1:0]),
      .res_valid (eng_valid),
      .res       (eng_res),
      .res_take  (eng_take)
   );

   assign eng_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (eng_take) begin
         rsp_valid_in = eng_valid;
         rsp_res_in   = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_res_ff.glyph_index};
   assign rsp_tuser  = {rsp_res_ff.used_fallback, rsp_res_ff.status};

endmodule

[hdl/gil_csr.sv]
// -----------------------------------------------------------------------------
// gil_csr
// Register file for the fallback settings, written and read over APB.
// -----------------------------------------------------------------------------
module gil_csr
   import gil_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic                fb_enable_ff, fb_enable_in;
   logic [DIRECT_W-1:0] fb_code_ff, fb_code_in;
   logic                wr_en;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      fb_enable_in = fb_enable_ff;
      fb_code_in   = fb_code_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_FB_ENABLE: fb_enable_in = csr_pwdata[0];
            REG_FB_CODE:   fb_code_in   = csr_pwdata[DIRECT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_enable_ff <= FB_ENABLE_RESET;
         fb_code_ff   <= FB_CODE_RESET;
      end else begin
         fb_enable_ff <= fb_enable_in;
         fb_code_ff   <= fb_code_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         REG_FB_ENABLE: csr_prdata = CSR_DATA_W'(fb_enable_ff);
         REG_FB_CODE:   csr_prdata = CSR_DATA_W'(fb_code_ff);
         default: ;
      endcase
   end

   assign cfg.enable = fb_enable_ff;
   assign cfg.code   = fb_code_ff;

endmodule

[hdl/gil_engine.sv]
// -----------------------------------------------------------------------------
// gil_engine
// Code table and direct map memories with the sequencer that appends codes,
// clears the table and runs the binary search and direct-map lookups.
// -----------------------------------------------------------------------------
module gil_engine
   import gil_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
)
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [CODE_W-1:0] req_code,
   output logic              res_valid,
   output res_type           res,
   input  logic              res_take
);

   localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = SW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [CODE_W-1:0] code_table [TABLE_DEPTH];
   logic [SW-1:0]     direct_map [DIRECT_SIZE];

   state_type             state_ff, state_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [SW-1:0]         base_ff, base_in;
   logic [CW-1:0]         len_ff, len_in;
   logic [CW-1:0]         half_ff, half_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  past_ff, past_in;
   logic [DIRECT_SIZE-1:0] valid_ff, valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic                  fb_ff, fb_in;

   logic                  tbl_we, tbl_re;
   logic [SW-1:0]         tbl_waddr, tbl_raddr;
   logic [CODE_W-1:0]     tbl_rdata_ff;
   logic                  dm_we, dm_re;
   logic [DIRECT_W-1:0]   dm_waddr, dm_raddr;
   logic [SW-1:0]         dm_rdata_ff;

   logic                  accept;
   logic                  is_low;
   logic                  low_valid;
   logic                  fb_try;
   logic                  full;
   logic                  found_final;
   logic                  le;
   logic [AW-1:0]         probe_sum;
   logic [SW-1:0]         base_step;
   logic [CW-1:0]         len_step;
   logic [CW-1:0]         half_step;
   logic [AW-1:0]         next_probe;
   logic [SW+GLYPH_W-1:0] slot_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   assign is_low    = (code_ff[CODE_W-1:DIRECT_W] == '0);
   assign low_valid = valid_ff[code_ff[DIRECT_W-1:0]];
   assign fb_try    = cfg.enable && (code_ff != CODE_W'(cfg.code)) && valid_ff[cfg.code];
   assign full      = (count_ff >= DEPTH_C);
   assign found_final = (tbl_rdata_ff == code_ff);
   assign le        = (tbl_rdata_ff <= code_ff);
   assign probe_sum = AW'(base_ff) + AW'(half_ff);
   assign base_step = le ? probe_sum[SW-1:0] : base_ff;
   assign len_step  = len_ff - half_ff;
   assign half_step = len_step >> 1;
   assign next_probe = AW'(base_step) + AW'(half_step);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            if (kind_ff == KIND_LOOKUP) begin
               if (is_low) begin
                  if (low_valid)   state_in = ST_DIRECT;
                  else if (fb_try) state_in = ST_FALLBACK;
               end else if (count_ff != '0) begin
                  state_in = ST_SEARCH;
               end else if (fb_try) begin
                  state_in = ST_FALLBACK;
               end
            end
         end
         ST_SEARCH: begin
            if (half_ff == '0) begin
               if (found_final)  state_in = ST_DONE;
               else if (fb_try)  state_in = ST_FALLBACK;
               else              state_in = ST_DONE;
            end
         end
         ST_DIRECT:   state_in = ST_DONE;
         ST_FALLBACK: state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      kind_in   = kind_ff;
      code_in   = code_ff;
      base_in   = base_ff;
      len_in    = len_ff;
      half_in   = half_ff;
      count_in  = count_ff;
      past_in   = past_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      fb_in     = fb_ff;
      tbl_we    = 1'b0;
      tbl_re    = 1'b0;
      tbl_waddr = count_ff[SW-1:0];
      tbl_raddr = '0;
      dm_we     = 1'b0;
      dm_re     = 1'b0;
      dm_waddr  = code_ff[DIRECT_W-1:0];
      dm_raddr  = code_ff[DIRECT_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               code_in = req_code;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            slot_in   = '0;
            fb_in     = 1'b0;
            case (kind_ff)
               KIND_CLEAR: begin
                  count_in = '0;
                  past_in  = 1'b0;
                  valid_in = '0;
               end
               KIND_APPEND: begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     tbl_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                     if (!past_ff && is_low) begin
                        dm_we = 1'b1;
                        valid_in[code_ff[DIRECT_W-1:0]] = 1'b1;
                     end else begin
                        past_in = 1'b1;
                     end
                  end
               end
               KIND_LOOKUP: begin
                  if (is_low) begin
                     if (low_valid) begin
                        dm_re = 1'b1;
                     end else if (fb_try) begin
                        dm_re    = 1'b1;
                        dm_raddr = cfg.code;
                     end else begin
                        status_in = STATUS_MISS;
                     end
                  end else if (count_ff != '0) begin
                     base_in   = '0;
                     len_in    = count_ff;
                     half_in   = count_ff >> 1;
                     tbl_re    = 1'b1;
                     tbl_raddr = half_in[SW-1:0];
                  end else if (fb_try) begin
                     dm_re    = 1'b1;
                     dm_raddr = cfg.code;
                  end else begin
                     status_in = STATUS_MISS;
                  end
               end
               default: ;
            endcase
         end
         ST_SEARCH: begin
            if (half_ff == '0) begin
               if (found_final) begin
                  slot_in = base_ff;
               end else if (fb_try) begin
                  dm_re    = 1'b1;
                  dm_raddr = cfg.code;
               end else begin
                  status_in = STATUS_MISS;
               end
            end else begin
               base_in   = base_step;
               len_in    = len_step;
               half_in   = half_step;
               tbl_re    = 1'b1;
               tbl_raddr = next_probe[SW-1:0];
            end
         end
         ST_DIRECT: begin
            slot_in = dm_rdata_ff;
         end
         ST_FALLBACK: begin
            slot_in = dm_rdata_ff;
            fb_in   = 1'b1;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         past_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         past_ff  <= past_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      code_ff   <= code_in;
      base_ff   <= base_in;
      len_ff    <= len_in;
      half_ff   <= half_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      fb_ff     <= fb_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) code_table[tbl_waddr] <= code_ff;
      if (tbl_re) tbl_rdata_ff <= code_table[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (dm_we) direct_map[dm_waddr] <= count_ff[SW-1:0];
      if (dm_re) dm_rdata_ff <= direct_map[dm_raddr];
   end

   assign slot_wide       = {{GLYPH_W{1'b0}}, slot_ff};
   assign res_valid       = (state_ff == ST_DONE);
   assign res.status      = status_ff;
   assign res.glyph_index = slot_wide[GLYPH_W-1:0];
   assign res.used_fallback = fb_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> probe_sum < AW'(count_ff))
      else $error("search probe outside loaded entries");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && kind_ff == KIND_CLEAR) |=> (count_ff == '0 && valid_ff == '0))
      else $error("clear left entries behind");

   a_fallback_found: assert property (@(posedge clock) disable iff (reset)
      (res_valid && fb_ff) |-> status_ff == STATUS_OK)
      else $error("fallback result without found status");
`endif

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// glyph_index_lookup testbench
// Streams clear, append and lookup words into the block and checks every
// result against an in-bench predictor of the code table, the direct map and
// the fallback retry. Runs a short directed set, then random phases under
// several fallback settings and idling patterns, including a long receiver
// hold-off.
// ---------------------------------------------------------------------------
module testbench;
   import gil_pkg::*;

   localparam int TBL_DEPTH = 4096;
   localparam int CODE_MAX = 1114111;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
   localparam int PHASE_WORDS = 150;
   localparam int REPORT_CAP = 100;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
   } lookup_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;   // code[20:0], zero pad
   logic [1:0]            req_tuser = '0;   // kind[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;        // glyph_index[11:0], zero pad
   logic [2:0]            rsp_tuser;        // status[1:0], used_fallback[2]
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   glyph_index_lookup #(.TABLE_DEPTH(TBL_DEPTH)) dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [CODE_W-1:0]  tbl_code [TBL_DEPTH];
   logic [GLYPH_W-1:0] low_slot [DIRECT_SIZE];
   bit                 low_valid [DIRECT_SIZE];
   int                 tbl_count = 0;
   bit                 high_seen = 0;
   logic               fb_on = FB_ENABLE_RESET;
   logic [DIRECT_W-1:0] fb_code_r = FB_CODE_RESET;

   lookup_word_type    req_words [$];
   res_type            due_results [$];
   int unsigned        loaded_codes [$];
   int                 mismatches = 0;
   int                 queued = 0;
   bit                 req_fire = 0;
   int                 send_gap_pct = 19;
   int                 recv_gap_pct = 72;
   bit                 hold_req = 0;
   int                 hold_left = 0;

   function automatic bit probe_slot(input logic [CODE_W-1:0] c,
                                     output logic [GLYPH_W-1:0] s);
      int unsigned len, half, base;
      s = '0;
      if (c < DIRECT_SIZE) begin
         if (!low_valid[c[DIRECT_W-1:0]]) return 1'b0;
         s = low_slot[c[DIRECT_W-1:0]];
         return 1'b1;
      end
      if (tbl_count == 0) return 1'b0;
      len = tbl_count;
      base = 0;
      do begin
         half = len >> 1;
         if (tbl_code[base + half] <= c) base += half;
         len -= half;
      end while (half > 0);
      if (tbl_code[base] != c) return 1'b0;
      s = base[GLYPH_W-1:0];
      return 1'b1;
   endfunction

   function automatic res_type predict_word(input lookup_word_type w);
      res_type r;
      logic [GLYPH_W-1:0] s;
      r = '0;
      r.status = STATUS_OK;
      case (w.kind)
         KIND_CLEAR: begin
            tbl_count = 0;
            high_seen = 0;
            foreach (low_valid[i]) low_valid[i] = 0;
         end
         KIND_APPEND: begin
            if (tbl_count >= TBL_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               tbl_code[tbl_count] = w.code;
               if (!high_seen && w.code < DIRECT_SIZE) begin
                  low_slot[w.code[DIRECT_W-1:0]] = tbl_count[GLYPH_W-1:0];
                  low_valid[w.code[DIRECT_W-1:0]] = 1;
               end else begin
                  high_seen = 1;
               end
               tbl_count++;
            end
         end
         KIND_LOOKUP: begin
            if (probe_slot(w.code, s)) begin
               r.glyph_index = s;
            end else if (fb_on && w.code != CODE_W'(fb_code_r) &&
                         probe_slot(CODE_W'(fb_code_r), s)) begin
               r.glyph_index = s;
               r.used_fallback = 1'b1;
            end else begin
               r.status = STATUS_MISS;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // monitor
   always @(posedge clock) begin
      lookup_word_type w;
      res_type got, want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            w.kind = req_tuser;
            w.code = req_tdata[CODE_W-1:0];
            due_results.push_back(predict_word(w));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser[1:0];
            got.used_fallback = rsp_tuser[2];
            got.glyph_index = rsp_tdata[GLYPH_W-1:0];
            if (due_results.size() == 0) begin
               report("unexpected result", 0, int'(got));
            end else begin
               want = due_results.pop_front();
               if (got.status !== want.status)
                  report("status", int'(want.status), int'(got.status));
               if (got.glyph_index !== want.glyph_index)
                  report("glyph_index", int'(want.glyph_index), int'(got.glyph_index));
               if (got.used_fallback !== want.used_fallback)
                  report("used_fallback", int'(want.used_fallback),
                         int'(got.used_fallback));
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      lookup_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_words.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            w = req_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {3'b000, w.code};
            req_tuser <= w.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 0;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   task automatic queue_word(input logic [KIND_W-1:0] k, input int unsigned c);
      lookup_word_type w;
      w.kind = k;
      w.code = c[CODE_W-1:0];
      req_words.push_back(w);
      queued++;
   endtask

   task automatic csr_access(input logic idx, input logic wr, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!wr && csr_prdata !== val) report("register readback", val, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_fallback(input logic en, input logic [DIRECT_W-1:0] code);
      csr_access(REG_FB_ENABLE, 1'b1, {31'd0, en});
      fb_on = en;
      csr_access(REG_FB_CODE, 1'b1, {25'd0, code});
      fb_code_r = code;
      csr_access(REG_FB_ENABLE, 1'b0, {31'd0, en});
      csr_access(REG_FB_CODE, 1'b0, {25'd0, code});
   endtask

   task automatic drain();
      while (req_words.size() > 0 || req_tvalid || due_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_sorted(input int n, input int unsigned jump);
      int nlow;
      int unsigned c;
      loaded_codes.delete();
      nlow = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : 0;
      c = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) begin
         if (i < nlow) begin
            c += $urandom_range(0, 6);
            if (c > DIRECT_SIZE - 1) c = DIRECT_SIZE - 1;
         end else if (c < DIRECT_SIZE) begin
            c = $urandom_range(0, 1) ? DIRECT_SIZE + $urandom_range(0, 300)
                                     : $urandom_range(DIRECT_SIZE, 900000);
         end else begin
            c += ($urandom_range(0, 3) == 0) ? $urandom_range(0, jump)
                                             : $urandom_range(0, 6);
            if (c > CODE_MAX) c = CODE_MAX;
         end
         queue_word(KIND_APPEND, c);
         loaded_codes.push_back(c);
      end
   endtask

   task automatic queue_lookups(input int m);
      int r;
      int unsigned c, pick;
      for (int i = 0; i < m; i++) begin
         r = $urandom_range(0, 99);
         pick = (loaded_codes.size() > 0) ?
                loaded_codes[$urandom_range(0, loaded_codes.size() - 1)] : 0;
         if (r < 40 && loaded_codes.size() > 0)
            c = pick;
         else if (r < 55 && loaded_codes.size() > 0)
            c = (pick == 0 || (pick < CODE_MAX && $urandom_range(0, 1))) ? pick + 1
                                                                          : pick - 1;
         else if (r < 70)
            c = $urandom_range(0, DIRECT_SIZE - 1);
         else if (r < 78)
            c = int'(fb_code_r);
         else
            c = $urandom_range(0, CODE_MAX);
         queue_word(KIND_LOOKUP, c);
      end
   endtask

   task automatic queue_random_phase();
      int r, n;
      int goal;
      goal = queued + PHASE_WORDS;
      while (queued < goal) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
            queue_word(KIND_CLEAR, $urandom_range(0, CODE_MAX));
            queue_sorted(n, 60000);
            queue_lookups(n + $urandom_range(0, n));
         end else if (r < 85) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
               loaded_codes.push_back($urandom_range(0, 1) ? $urandom_range(0, DIRECT_SIZE - 1)
                                                           : $urandom_range(0, CODE_MAX));
               queue_word(KIND_APPEND, loaded_codes[$]);
            end
            queue_lookups(n);
         end else if (r < 92) begin
            repeat ($urandom_range(1, 3)) queue_word(KIND_IGNORED, $urandom_range(0, CODE_MAX));
         end else begin
            repeat ($urandom_range(1, 4))
               queue_word(KIND_W'($urandom_range(0, 3)), $urandom_range(0, CODE_MAX));
         end
      end
   endtask

   initial begin
      #12_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      foreach (low_valid[i]) low_valid[i] = 0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, fallback at reset value
      queue_word(KIND_LOOKUP, CODE_MAX);
      queue_word(KIND_LOOKUP, 0);
      queue_word(KIND_LOOKUP, int'(FB_CODE_RESET));
      queue_word(KIND_CLEAR, 0);
      queue_word(KIND_APPEND, 0);
      queue_word(KIND_APPEND, int'(FB_CODE_RESET));
      queue_word(KIND_APPEND, DIRECT_SIZE - 1);
      queue_word(KIND_APPEND, DIRECT_SIZE - 1);
      queue_word(KIND_APPEND, DIRECT_SIZE);
      queue_word(KIND_APPEND, 5);
      queue_word(KIND_APPEND, CODE_MAX);
      queue_word(KIND_LOOKUP, 0);
      queue_word(KIND_LOOKUP, DIRECT_SIZE - 1);
      queue_word(KIND_LOOKUP, DIRECT_SIZE);
      queue_word(KIND_LOOKUP, CODE_MAX);
      queue_word(KIND_LOOKUP, 5);
      queue_word(KIND_LOOKUP, 300);
      queue_word(KIND_IGNORED, CODE_MAX);
      queue_word(KIND_IGNORED, 0);
      queue_word(KIND_CLEAR, CODE_MAX);
      queue_word(KIND_LOOKUP, int'(FB_CODE_RESET));
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: apply_fallback(1'b0, 7'd0);
            1: apply_fallback(1'b1, 7'd0);
            2: begin
               send_gap_pct = 72;
               recv_gap_pct = 19;
               apply_fallback(1'b1, 7'd127);
            end
            3: apply_fallback(1'b0, 7'd127);
            4: apply_fallback(1'($urandom_range(0, 1)), DIRECT_W'($urandom_range(0, 127)));
            5: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
               apply_fallback(1'b1, DIRECT_W'($urandom_range(0, 127)));
            end
            default: apply_fallback(FB_ENABLE_RESET, FB_CODE_RESET);
         endcase
         if (ph == 5) begin
            // load a long table, then hold off the receiver
            queue_word(KIND_CLEAR, 0);
            queue_sorted(120, 400);
            queue_lookups(60);
            @(posedge clock);
            hold_req = 1;
         end
         queue_random_phase();
         drain();
      end

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
hdl/gil_pkg.sv
hdl/gil_csr.sv
hdl/gil_engine.sv
hdl/glyph_index_lookup.sv
verif/testbench.sv
